@@ design/motor_command_frame_encoder_macros.svh @@
// Assertion macros shared by the frame encoder RTL.
`ifndef MOTOR_COMMAND_FRAME_ENCODER_MACROS_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define MCFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame encoder check failed");

// Next-cycle implication, checked outside reset.
`define MCFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame encoder check failed");

`else

`define MCFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MCFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/mcfe_pkg.sv @@
// Types, constants and CRC function of the motor command frame encoder.
`default_nettype none

package mcfe_pkg;

    // Command item as it enters the block
    typedef struct packed {
        logic        [3:0]  motor_id;
        logic        [3:0]  mode;
        logic signed [23:0] torque;
        logic signed [23:0] velocity;
        logic signed [39:0] position;
        logic signed [23:0] stiffness;
        logic signed [23:0] damping;
    } cmd_t;

    // One frame byte as it leaves the block
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } frm_t;

    localparam int FRAME_LEN = 17;
    localparam int CRC_POS   = 15;

    localparam logic [7:0]  HDR0 = 8'hFE;
    localparam logic [7:0]  HDR1 = 8'hEE;

    // Saturation limits on magnitudes
    localparam logic [23:0] TORQUE_MAX = 24'd32765;
    localparam logic [23:0] VEL_MAX    = 24'd205824;
    localparam logic [39:0] POS_MAX    = 40'd13493010432;
    localparam logic [23:0] GAIN_MAX   = 24'd32766;

    // 1/(2*pi) in Q0.28
    localparam logic [25:0] INV_TWO_PI = 26'd42722830;
    localparam int          TURN_SHIFT = 28;

    // Reflected CRC-16 polynomial
    localparam logic [15:0] CRC_POLY = 16'h8408;

    // Fold one byte into the running CRC, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/motor_command_frame_encoder.sv @@
// Motor command frame encoder: saturate, scale to turns, frame and CRC.
//
//  Channel | Handshake          | Payload            | Role
//  --------+--------------------+--------------------+-----------------------------
//  cmd     | cmd_valid/stall    | mcfe_pkg::cmd_t    | one motor command per item
//  frm     | frm_valid/stall    | mcfe_pkg::frm_t    | one frame byte per item, 17 a frame
//
// A command passes three register stages (saturate, multiply, add and shift) and
// then loads the frame register, which drives its first byte onto frm.
// The frame register sends one byte per cycle while frm is not stalled, and the front
// stages take new commands while a frame is sent; the next command loads in the same
// cycle the last byte is taken. The CRC is folded in byte by byte as bytes leave.
// Reset clears all valid bits and the byte counter; payload holds no reset value.
// A stall on frm freezes the current byte and backs up the stages behind it.
`default_nettype none
`include "motor_command_frame_encoder_macros.svh"

module motor_command_frame_encoder (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire mcfe_pkg::cmd_t cmd,
    output logic                frm_valid,
    input  wire logic           frm_stall,
    output mcfe_pkg::frm_t      frm
);
    import mcfe_pkg::*;

    // Stage 1: saturated values, magnitudes and signs
    logic        s1_valid_reg;
    logic [7:0]  s1_idm_reg;
    logic [15:0] s1_tq_reg;
    logic [15:0] s1_kp_reg;
    logic [15:0] s1_kd_reg;
    logic        s1_vneg_reg;
    logic [17:0] s1_vmag_reg;
    logic        s1_pneg_reg;
    logic [33:0] s1_pmag_reg;

    // Stage 2: partial products
    logic        s2_valid_reg;
    logic [7:0]  s2_idm_reg;
    logic [15:0] s2_tq_reg;
    logic [15:0] s2_kp_reg;
    logic [15:0] s2_kd_reg;
    logic        s2_vneg_reg;
    logic        s2_pneg_reg;
    logic [43:0] s2_vprod_reg;
    logic [42:0] s2_plo_reg;
    logic [42:0] s2_phi_reg;

    // Stage 3: turn magnitudes
    logic        s3_valid_reg;
    logic [7:0]  s3_idm_reg;
    logic [15:0] s3_tq_reg;
    logic [15:0] s3_kp_reg;
    logic [15:0] s3_kd_reg;
    logic        s3_vneg_reg;
    logic        s3_pneg_reg;
    logic [15:0] s3_qv_reg;
    logic [31:0] s3_qp_reg;

    // Frame register and serializer
    logic        f_valid_reg;
    logic [7:0]  f_idm_reg;
    logic [15:0] f_tq_reg;
    logic [15:0] f_vb_reg;
    logic [31:0] f_pb_reg;
    logic [15:0] f_kp_reg;
    logic [15:0] f_kd_reg;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    logic        ld1;
    logic        ld2;
    logic        ld3;
    logic        ldf;
    logic        out_take;
    logic        at_last;

    // Stage 1 combinational
    logic [23:0] tq_abs;
    logic [23:0] v_abs;
    logic [39:0] p_abs;
    logic [15:0] tq_sat;
    logic [17:0] v_mag;
    logic [33:0] p_mag;
    logic [15:0] kp_cl;
    logic [15:0] kd_cl;

    // Stage 3 combinational
    logic [59:0] psum;

    // Output byte
    logic [7:0]  tx_sel;

    // Load enables: a stage loads when empty or when its content moves on
    assign at_last   = (cnt_reg == 5'(FRAME_LEN - 1));
    assign out_take  = f_valid_reg && !frm_stall;
    assign ldf       = !f_valid_reg || (out_take && at_last);
    assign ld3       = !s3_valid_reg || ldf;
    assign ld2       = !s2_valid_reg || ld3;
    assign ld1       = !s1_valid_reg || ld2;
    assign cmd_stall = !ld1;

    // Saturate and take magnitudes
    always_comb
    begin
        tq_abs = cmd.torque[23]   ? (24'd0 - cmd.torque)   : cmd.torque;
        v_abs  = cmd.velocity[23] ? (24'd0 - cmd.velocity) : cmd.velocity;
        p_abs  = cmd.position[39] ? (40'd0 - cmd.position) : cmd.position;

        if (tq_abs > TORQUE_MAX)
            tq_sat = cmd.torque[23] ? (16'd0 - TORQUE_MAX[15:0]) : TORQUE_MAX[15:0];
        else
            tq_sat = cmd.torque[15:0];

        v_mag = (v_abs > VEL_MAX) ? VEL_MAX[17:0] : v_abs[17:0];
        p_mag = (p_abs > POS_MAX) ? POS_MAX[33:0] : p_abs[33:0];

        if (cmd.stiffness[23])
            kp_cl = 16'd0;
        else if (cmd.stiffness > $signed(GAIN_MAX))
            kp_cl = GAIN_MAX[15:0];
        else
            kp_cl = cmd.stiffness[15:0];

        if (cmd.damping[23])
            kd_cl = 16'd0;
        else if (cmd.damping > $signed(GAIN_MAX))
            kd_cl = GAIN_MAX[15:0];
        else
            kd_cl = cmd.damping[15:0];
    end

    // Advance the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                s1_valid_reg <= cmd_valid;
            if (ld2)
                s2_valid_reg <= s1_valid_reg;
            if (ld3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_idm_reg  <= {cmd.mode, cmd.motor_id};
            s1_tq_reg   <= tq_sat;
            s1_kp_reg   <= kp_cl;
            s1_kd_reg   <= kd_cl;
            s1_vneg_reg <= cmd.velocity[23];
            s1_vmag_reg <= v_mag;
            s1_pneg_reg <= cmd.position[39];
            s1_pmag_reg <= p_mag;
        end
    end

    // Stage 2 payload: multiply by 1/(2*pi), position split in two halves
    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_idm_reg   <= s1_idm_reg;
            s2_tq_reg    <= s1_tq_reg;
            s2_kp_reg    <= s1_kp_reg;
            s2_kd_reg    <= s1_kd_reg;
            s2_vneg_reg  <= s1_vneg_reg;
            s2_pneg_reg  <= s1_pneg_reg;
            s2_vprod_reg <= 44'(s1_vmag_reg) * 44'(INV_TWO_PI);
            s2_plo_reg   <= 43'(s1_pmag_reg[16:0]) * 43'(INV_TWO_PI);
            s2_phi_reg   <= 43'(s1_pmag_reg[33:17]) * 43'(INV_TWO_PI);
        end
    end

    // Join the position halves
    assign psum = {s2_phi_reg[42:0], 17'd0} + {17'd0, s2_plo_reg};

    // Stage 3 payload: drop the fraction
    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_idm_reg  <= s2_idm_reg;
            s3_tq_reg   <= s2_tq_reg;
            s3_kp_reg   <= s2_kp_reg;
            s3_kd_reg   <= s2_kd_reg;
            s3_vneg_reg <= s2_vneg_reg;
            s3_pneg_reg <= s2_pneg_reg;
            s3_qv_reg   <= s2_vprod_reg[43:TURN_SHIFT];
            s3_qp_reg   <= psum[59:TURN_SHIFT];
        end
    end

    // Frame payload: restore signs
    always_ff @(posedge clk)
    begin
        if (ldf)
        begin
            f_idm_reg <= s3_idm_reg;
            f_tq_reg  <= s3_tq_reg;
            f_vb_reg  <= s3_vneg_reg ? (16'd0 - s3_qv_reg) : s3_qv_reg;
            f_pb_reg  <= s3_pneg_reg ? (32'd0 - s3_qp_reg) : s3_qp_reg;
            f_kp_reg  <= s3_kp_reg;
            f_kd_reg  <= s3_kd_reg;
        end
    end

    // Pick the byte at the current frame position
    always_comb
    begin
        case (cnt_reg)
            5'd0:    tx_sel = HDR0;
            5'd1:    tx_sel = HDR1;
            5'd2:    tx_sel = f_idm_reg;
            5'd3:    tx_sel = f_tq_reg[7:0];
            5'd4:    tx_sel = f_tq_reg[15:8];
            5'd5:    tx_sel = f_vb_reg[7:0];
            5'd6:    tx_sel = f_vb_reg[15:8];
            5'd7:    tx_sel = f_pb_reg[7:0];
            5'd8:    tx_sel = f_pb_reg[15:8];
            5'd9:    tx_sel = f_pb_reg[23:16];
            5'd10:   tx_sel = f_pb_reg[31:24];
            5'd11:   tx_sel = f_kp_reg[7:0];
            5'd12:   tx_sel = f_kp_reg[15:8];
            5'd13:   tx_sel = f_kd_reg[7:0];
            5'd14:   tx_sel = f_kd_reg[15:8];
            5'd15:   tx_sel = crc_reg[7:0];
            5'd16:   tx_sel = crc_reg[15:8];
            default: tx_sel = 8'h00;
        endcase
    end

    assign frm_valid   = f_valid_reg;
    assign frm.tx_byte = tx_sel;
    assign frm.last    = at_last;

    // Step the byte counter and fold sent bytes ahead of the CRC field into the CRC
    always_comb
    begin
        cnt_next = cnt_reg;
        crc_next = crc_reg;
        if (ldf)
        begin
            cnt_next = 5'd0;
            crc_next = 16'd0;
        end
        else if (out_take)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg < 5'(CRC_POS))
                crc_next = crc_byte(crc_reg, tx_sel);
        end
    end

    // Frame control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            cnt_reg     <= 5'd0;
            crc_reg     <= 16'd0;
        end
        else
        begin
            if (ldf)
                f_valid_reg <= s3_valid_reg;
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
        end
    end

    // A frame that has started is sent to the end
    `MCFE_ASSERT_NXT(a_frame_holds, clk, rst_n, f_valid_reg && !at_last, f_valid_reg)
    // A byte taken before the last keeps the frame valid
    `MCFE_ASSERT_NXT(a_no_drop, clk, rst_n, out_take && !at_last, f_valid_reg && cnt_reg != 5'd0)
    // After the last byte, the next output starts with the header
    `MCFE_ASSERT_NXT(a_next_hdr, clk, rst_n, out_take && at_last,
        !f_valid_reg || (cnt_reg == 5'd0 && frm.tx_byte == HDR0))
    // Input stalls only when the first stage is full and blocked
    `MCFE_ASSERT_IMP(a_stall_cause, clk, rst_n, cmd_stall, s1_valid_reg && s2_valid_reg)
    // The byte counter stays inside the frame
    `MCFE_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg < 5'(FRAME_LEN))

endmodule

`default_nettype wire

@@ tb/motor_command_frame_encoder_tb.sv @@
// Self-checking testbench for the motor command frame encoder.
module motor_command_frame_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcfe_pkg::*;

    localparam int          BYTES_PER_FRAME = 17;
    localparam logic [7:0]  SYNC0           = 8'hFE;
    localparam logic [7:0]  SYNC1           = 8'hEE;
    localparam longint      TORQUE_LIM      = 64'sd32765;
    localparam longint      SPEED_LIM       = 64'sd205824;
    localparam longint      ANGLE_LIM       = 64'sd13493010432;
    localparam longint      GAIN_LIM        = 64'sd32766;
    localparam logic [63:0] TURNS_Q28       = 64'd42722830;
    localparam int          TURNS_FRAC      = 28;
    localparam logic [15:0] CRC16_REFL_POLY = 16'h8408;
    localparam int          RANDOM_CMDS     = 220;
    localparam int          DRAIN_EVERY     = 70;
    localparam int          IDLE_LIMIT      = 2000;
    localparam int          TAIL_CYCLES     = 24;

    // receiver stall patterns
    localparam int STALL_NONE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;
    localparam int STALL_MASK  = 3;

    typedef struct packed {
        logic drain_first;
        cmd_t cmd;
    } cmd_slot_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic frm_valid;
    logic frm_stall = 1'b0;
    frm_t frm;

    cmd_slot_t   cmds_pending[$];
    frm_t        bytes_due[$];
    logic        cmd_taken     = 1'b0;
    int unsigned cmds_accepted = 0;
    int unsigned bytes_checked = 0;
    int unsigned mismatches    = 0;
    int unsigned idle_cycles   = 0;
    int          burst_left    = 0;
    int          gap_left      = 0;
    int          stall_mode    = STALL_NONE;
    int          mode_cycles   = 0;
    logic [7:0]  stall_mask    = 8'b0010_0110;

    motor_command_frame_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .frm_valid (frm_valid),
        .frm_stall (frm_stall),
        .frm       (frm)
    );

    always #5 clk = ~clk;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Scale by 1/(2*pi), truncating toward zero
    function automatic logic [63:0] to_turns_q(longint v);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (v < 0) ? -v : v;
        q   = (mag * TURNS_Q28) >> TURNS_FRAC;
        return (v < 0) ? -q : q;
    endfunction

    // Reflected CRC-16, one data bit at a time
    function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb)
                crc = crc ^ CRC16_REFL_POLY;
        end
        return crc;
    endfunction

    // Build the 17-byte frame of one command and queue its bytes
    function automatic void encode_frame(cmd_t c);
        logic [7:0]  f [BYTES_PER_FRAME];
        logic [63:0] tq;
        logic [63:0] vb;
        logic [63:0] pb;
        logic [63:0] kp;
        logic [63:0] kd;
        logic [15:0] crc;
        frm_t        b;
        tq  = clip(longint'($signed(c.torque)), -TORQUE_LIM, TORQUE_LIM);
        vb  = to_turns_q(clip(longint'($signed(c.velocity)), -SPEED_LIM, SPEED_LIM));
        pb  = to_turns_q(clip(longint'($signed(c.position)), -ANGLE_LIM, ANGLE_LIM));
        kp  = clip(longint'($signed(c.stiffness)), 0, GAIN_LIM);
        kd  = clip(longint'($signed(c.damping)), 0, GAIN_LIM);
        f[0]  = SYNC0;
        f[1]  = SYNC1;
        f[2]  = {c.mode, c.motor_id};
        f[3]  = tq[7:0];
        f[4]  = tq[15:8];
        f[5]  = vb[7:0];
        f[6]  = vb[15:8];
        f[7]  = pb[7:0];
        f[8]  = pb[15:8];
        f[9]  = pb[23:16];
        f[10] = pb[31:24];
        f[11] = kp[7:0];
        f[12] = kp[15:8];
        f[13] = kd[7:0];
        f[14] = kd[15:8];
        crc = 16'h0000;
        for (int k = 0; k < BYTES_PER_FRAME - 2; k++)
            crc = crc16_fold(crc, f[k]);
        f[15] = crc[7:0];
        f[16] = crc[15:8];
        for (int k = 0; k < BYTES_PER_FRAME; k++)
        begin
            b.tx_byte = f[k];
            b.last    = (k == BYTES_PER_FRAME - 1);
            bytes_due.push_back(b);
        end
    endfunction

    function automatic void add_cmd(logic [3:0] id, logic [3:0] md, longint tq, longint ve,
                                    longint po, longint kp, longint kd, logic drain);
        cmd_slot_t s;
        s.drain_first   = drain;
        s.cmd.motor_id  = id;
        s.cmd.mode      = md;
        s.cmd.torque    = tq[23:0];
        s.cmd.velocity  = ve[23:0];
        s.cmd.position  = po[39:0];
        s.cmd.stiffness = kp[23:0];
        s.cmd.damping   = kd[23:0];
        cmds_pending.push_back(s);
    endfunction

    // Mix raw bits, in-range values, values near a limit and values near zero
    function automatic longint pick_value(longint limit);
        case ($urandom_range(0, 4))
            0, 1:    return longint'({$urandom, $urandom});
            2:       return longint'({$urandom, $urandom} % (2 * limit + 1)) - limit;
            3:       return ($urandom_range(0, 1) ? limit : -limit)
                            + longint'($urandom_range(0, 4)) - 2;
            default: return longint'($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    // Drive command items and receiver stall at the falling edge
    always @(negedge clk)
    begin : drive_inputs
        logic      next_valid;
        cmd_t      next_cmd;
        cmd_slot_t slot;
        if (rst_n)
        begin
            next_valid = cmd_valid;
            next_cmd   = cmd;
            // drop the item the block took at the last edge
            if (cmd_valid && cmd_taken)
                next_valid = 1'b0;
            if (!next_valid && cmds_pending.size() != 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!(cmds_pending[0].drain_first && bytes_due.size() != 0))
                begin
                    slot       = cmds_pending.pop_front();
                    next_valid = 1'b1;
                    next_cmd   = slot.cmd;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 7);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
            end
            cmd_valid <= next_valid;
            cmd       <= next_cmd;

            // advance the receiver stall pattern
            if (mode_cycles == 0)
            begin
                stall_mode  = $urandom_range(0, 3);
                mode_cycles = $urandom_range(20, 80);
            end
            mode_cycles--;
            stall_mask = {stall_mask[6:0], stall_mask[7]};
            case (stall_mode)
                STALL_LIGHT: frm_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: frm_stall <= ($urandom_range(0, 3) != 0);
                STALL_MASK:  frm_stall <= stall_mask[0];
                default:     frm_stall <= 1'b0;
            endcase
        end
    end

    // Predict on command acceptance, check each frame byte, run the watchdog
    always @(posedge clk)
    begin : watch_outputs
        frm_t want;
        if (rst_n)
        begin
            cmd_taken <= cmd_valid && !cmd_stall;
            if (cmd_valid && !cmd_stall)
            begin
                encode_frame(cmd);
                cmds_accepted++;
            end
            if (frm_valid && !frm_stall)
            begin
                if (bytes_due.size() == 0)
                begin
                    $error("unexpected frame byte %02h (last=%0b)", frm.tx_byte, frm.last);
                    mismatches++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (frm.tx_byte !== want.tx_byte)
                    begin
                        $error("tx_byte: expected %02h, got %02h", want.tx_byte, frm.tx_byte);
                        mismatches++;
                    end
                    if (frm.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, frm.last);
                        mismatches++;
                    end
                    bytes_checked++;
                end
            end
            if ((cmd_valid && !cmd_stall) || (frm_valid && !frm_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d bytes outstanding",
                         idle_cycles, bytes_due.size());
                $display("[motor_command_frame_encoder] ERROR");
                $finish;
            end
        end
    end

    // Fill the command queue, release reset, wait for the last frame
    initial
    begin
        // zero, field extremes, saturation edges
        add_cmd(4'd0, 4'd0, 0, 0, 0, 0, 0, 1'b0);
        add_cmd(4'd15, 4'd15, 8388607, 8388607, 64'sd549755813887, 8388607, 8388607, 1'b0);
        add_cmd(4'd5, 4'd1, -8388608, -8388608, -64'sd549755813888, -8388608, -8388608,
                1'b0);
        add_cmd(4'd1, 4'd1, TORQUE_LIM, SPEED_LIM, ANGLE_LIM, GAIN_LIM, GAIN_LIM, 1'b0);
        add_cmd(4'd2, 4'd2, -TORQUE_LIM, -SPEED_LIM, -ANGLE_LIM, 0, 0, 1'b0);
        add_cmd(4'd3, 4'd0, TORQUE_LIM + 1, SPEED_LIM + 1, ANGLE_LIM + 1,
                GAIN_LIM + 1, GAIN_LIM + 1, 1'b0);
        add_cmd(4'd4, 4'd1, -TORQUE_LIM - 1, -SPEED_LIM - 1, -ANGLE_LIM - 1, -1, -1, 1'b0);
        // truncation toward zero of small turns
        add_cmd(4'd6, 4'd1, 1, 6, -7, 1, 2, 1'b0);
        add_cmd(4'd7, 4'd2, -1, -6, 7, 2, 1, 1'b0);
        add_cmd(4'd8, 4'd0, 256, 1, 1, 32765, 1280, 1'b0);
        add_cmd(4'd9, 4'd0, -256, -1, -1, 1280, 32765, 1'b0);
        // undefined mode codes pass through
        add_cmd(4'd10, 4'd3, 1000, -20000, 300000000, 640, 1280, 1'b0);
        add_cmd(4'd11, 4'd9, -1000, 20000, -300000000, 12800, 6400, 1'b0);
        // start after a full drain
        add_cmd(4'd1, 4'd2, 12345, -54321, 987654321, 1280, 640, 1'b1);
        add_cmd(4'd12, 4'd14, -12345, 54321, -987654321, 32766, 0, 1'b0);

        for (int n = 0; n < RANDOM_CMDS; n++)
            add_cmd(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    pick_value(TORQUE_LIM), pick_value(SPEED_LIM), pick_value(ANGLE_LIM),
                    pick_value(GAIN_LIM), pick_value(GAIN_LIM),
                    (n % DRAIN_EVERY) == DRAIN_EVERY - 1);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmds_pending.size() != 0 || cmd_valid)
            @(posedge clk);
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands (saturation and clamp edges, all modes, drained pauses)",
                 cmds_accepted);
        $display("and checked %0d frame bytes under sender bursts and receiver stalls.",
                 bytes_checked);
        if (mismatches == 0 && bytes_due.size() == 0)
            $display("[motor_command_frame_encoder] OK");
        else
            $display("[motor_command_frame_encoder] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/mcfe_pkg.sv
design/motor_command_frame_encoder.sv
tb/motor_command_frame_encoder_tb.sv
